// ===== src/dsf_pkg.sv =====
package dsf_pkg;

  localparam int SQ_STEPS  = 33;
  localparam int DIV_STEPS = 31;
  localparam int POST_STAGES = 10;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_STIFFNESS  = 3'd0;
  localparam reg_idx_t REG_FREE_LENGTH = 3'd1;
  localparam reg_idx_t REG_DAMPING    = 3'd2;
  localparam reg_idx_t REG_ANCHOR_X   = 3'd3;
  localparam reg_idx_t REG_ANCHOR_Y   = 3'd4;
  localparam reg_idx_t REG_MIN_LENGTH = 3'd5;

  localparam logic [31:0] STIFFNESS_RST  = 32'd65536;
  localparam logic [30:0] FREE_LENGTH_RST = 31'd65536;
  localparam logic [15:0] MIN_LENGTH_RST = 16'd66;

  // end geometry, carried through the length stages
  typedef struct packed {
    logic [31:0] dx_mag;
    logic [31:0] dy_mag;
    logic        dx_neg;
    logic        dy_neg;
    logic [31:0] dvx_mag;
    logic [31:0] dvy_mag;
    logic        dvx_neg;
    logic        dvy_neg;
    logic        apply_a;
    logic        apply_b;
  } geo_t;

  typedef struct packed {
    logic [32:0] len;
    logic        collapsed;
    logic [32:0] disp_mag;
    logic        disp_neg;
  } len_t;

  typedef struct packed {
    logic        apply_a;
    logic        apply_b;
    logic        collapsed;
    logic        dx_neg;
    logic        dy_neg;
    logic [30:0] qx;
    logic [30:0] qy;
  } post_t;

endpackage

// ===== src/damped_spring_force.sv =====
// damped 2d spring force: per request, the ends are resolved (a detached end sits at
// the anchor with zero velocity), the length is found by a 33-stage square-root
// pipeline (one root bit per stage), the unit direction by two 31-stage restoring
// dividers in parallel (one quotient bit per stage), and the spring and axial damping
// terms by a 10-stage multiply pipeline. one request is taken every cycle unless the
// pipeline holds; results leave through the output register, which parts the two
// sides: requests keep entering while a result waits, and the pipeline only holds
// when the output is stalled and the last stage is also full. force_x/force_y are
// the force on end a in saturated signed q16.16; end b gets the negation. a spring
// shorter than min_length (or of zero length) gives zero force, no apply flags and
// collapsed set. configuration is written over the apb port while no request is in
// flight; registers sit at byte addresses 0,4,..,20.
module damped_spring_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               a_attached,
  input  logic               b_attached,
  input  logic               a_static,
  input  logic               b_static,
  input  logic signed [31:0] pos_a_x,
  input  logic signed [31:0] pos_a_y,
  input  logic signed [31:0] pos_b_x,
  input  logic signed [31:0] pos_b_y,
  input  logic signed [31:0] vel_a_x,
  input  logic signed [31:0] vel_a_y,
  input  logic signed [31:0] vel_b_x,
  input  logic signed [31:0] vel_b_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic               apply_a,
  output logic               apply_b,
  output logic               collapsed
);
  import dsf_pkg::*;

  // configuration registers
  logic [31:0] stiffness;
  logic [30:0] free_length;
  logic [31:0] damping;
  logic [31:0] anchor_x;
  logic [31:0] anchor_y;
  logic [15:0] min_length;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= STIFFNESS_RST;
      free_length <= FREE_LENGTH_RST;
      damping     <= '0;
      anchor_x    <= '0;
      anchor_y    <= '0;
      min_length  <= MIN_LENGTH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STIFFNESS:   stiffness   <= pwdata;
        REG_FREE_LENGTH: free_length <= pwdata[30:0];
        REG_DAMPING:     damping     <= pwdata;
        REG_ANCHOR_X:    anchor_x    <= pwdata;
        REG_ANCHOR_Y:    anchor_y    <= pwdata;
        REG_MIN_LENGTH:  min_length  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STIFFNESS:   prdata = stiffness;
      REG_FREE_LENGTH: prdata = {1'b0, free_length};
      REG_DAMPING:     prdata = damping;
      REG_ANCHOR_X:    prdata = anchor_x;
      REG_ANCHOR_Y:    prdata = anchor_y;
      REG_MIN_LENGTH:  prdata = {16'd0, min_length};
      default:         prdata = '0;
    endcase
  end

  // flow control: the whole pipeline advances unless the output is stalled
  // while the last stage also holds a result
  logic en;
  logic last_vld;
  logic out_take;

  assign en       = !(out_valid && out_stall && last_vld);
  assign in_stall = !en;
  assign out_take = !out_valid || !out_stall;

  // stage 1: resolve ends, deltas and their magnitudes
  logic [31:0] ax, ay, bx, by, vax, vay, vbx, vby;
  logic [32:0] dx, dy, dvx, dvy, ndx, ndy, ndvx, ndvy;
  geo_t        s1_geo_next;

  always_comb begin
    ax  = a_attached ? pos_a_x : anchor_x;
    ay  = a_attached ? pos_a_y : anchor_y;
    bx  = b_attached ? pos_b_x : anchor_x;
    by  = b_attached ? pos_b_y : anchor_y;
    vax = a_attached ? vel_a_x : 32'd0;
    vay = a_attached ? vel_a_y : 32'd0;
    vbx = b_attached ? vel_b_x : 32'd0;
    vby = b_attached ? vel_b_y : 32'd0;
    dx  = {bx[31], bx} - {ax[31], ax};
    dy  = {by[31], by} - {ay[31], ay};
    dvx = {vax[31], vax} - {vbx[31], vbx};
    dvy = {vay[31], vay} - {vby[31], vby};
    ndx  = -dx;
    ndy  = -dy;
    ndvx = -dvx;
    ndvy = -dvy;
    s1_geo_next.dx_mag  = dx[32] ? ndx[31:0] : dx[31:0];
    s1_geo_next.dy_mag  = dy[32] ? ndy[31:0] : dy[31:0];
    s1_geo_next.dx_neg  = dx[32];
    s1_geo_next.dy_neg  = dy[32];
    s1_geo_next.dvx_mag = dvx[32] ? ndvx[31:0] : dvx[31:0];
    s1_geo_next.dvy_mag = dvy[32] ? ndvy[31:0] : dvy[31:0];
    s1_geo_next.dvx_neg = dvx[32];
    s1_geo_next.dvy_neg = dvy[32];
    s1_geo_next.apply_a = a_attached && !a_static;
    s1_geo_next.apply_b = b_attached && !b_static;
  end

  geo_t        s1_geo, s2_geo, s3_geo;
  logic        s1_vld, s2_vld, s3_vld;
  logic [63:0] s2_sqx, s2_sqy;
  logic [65:0] s3_sum;

  // square-root pipeline, one root bit per stage
  logic [34:0] sq_rem  [SQ_STEPS];
  logic [32:0] sq_root [SQ_STEPS];
  logic [65:0] sq_rad  [SQ_STEPS];
  geo_t        sq_geo  [SQ_STEPS];
  logic        sq_vld  [SQ_STEPS];
  logic [34:0] sq_srem [SQ_STEPS];
  logic [32:0] sq_sroot[SQ_STEPS];
  logic [65:0] sq_srad [SQ_STEPS];
  logic [36:0] sq_cur  [SQ_STEPS];
  logic [36:0] sq_trial[SQ_STEPS];
  logic        sq_ge   [SQ_STEPS];
  logic [34:0] sq_rem_next [SQ_STEPS];
  logic [32:0] sq_root_next[SQ_STEPS];
  logic [65:0] sq_rad_next [SQ_STEPS];

  always_comb begin
    sq_srem[0]  = '0;
    sq_sroot[0] = '0;
    sq_srad[0]  = s3_sum;
    for (int j = 1; j < SQ_STEPS; j++) begin
      sq_srem[j]  = sq_rem[j-1];
      sq_sroot[j] = sq_root[j-1];
      sq_srad[j]  = sq_rad[j-1];
    end
    for (int j = 0; j < SQ_STEPS; j++) begin
      sq_cur[j]       = {sq_srem[j], sq_srad[j][65:64]};
      sq_trial[j]     = {2'b00, sq_sroot[j], 2'b01};
      sq_ge[j]        = sq_cur[j] >= sq_trial[j];
      sq_rem_next[j]  = sq_ge[j] ? 35'(sq_cur[j] - sq_trial[j]) : sq_cur[j][34:0];
      sq_root_next[j] = {sq_sroot[j][31:0], sq_ge[j]};
      sq_rad_next[j]  = {sq_srad[j][63:0], 2'b00};
    end
  end

  // length checks, then restoring dividers for the unit direction
  len_t        len_next;
  logic [32:0] rest_ext;
  logic        rest_le;

  always_comb begin
    rest_ext           = {2'b00, free_length};
    rest_le            = sq_root[SQ_STEPS-1] >= rest_ext;
    len_next.len       = sq_root[SQ_STEPS-1];
    len_next.collapsed = (sq_root[SQ_STEPS-1] == 33'd0) ||
                         (sq_root[SQ_STEPS-1] < {17'd0, min_length});
    len_next.disp_mag  = rest_le ? sq_root[SQ_STEPS-1] - rest_ext
                                 : rest_ext - sq_root[SQ_STEPS-1];
    len_next.disp_neg  = !rest_le;
  end

  logic [32:0] dv_remx [DIV_STEPS];
  logic [32:0] dv_remy [DIV_STEPS];
  logic [30:0] dv_qx   [DIV_STEPS];
  logic [30:0] dv_qy   [DIV_STEPS];
  len_t        dv_len  [DIV_STEPS];
  geo_t        dv_geo  [DIV_STEPS];
  logic        dv_vld  [DIV_STEPS];
  logic [32:0] dv_sremx[DIV_STEPS];
  logic [32:0] dv_sremy[DIV_STEPS];
  logic        dv_bitx [DIV_STEPS];
  logic        dv_bity [DIV_STEPS];
  logic [30:0] dv_sqx  [DIV_STEPS];
  logic [30:0] dv_sqy  [DIV_STEPS];
  logic [32:0] dv_slen [DIV_STEPS];
  logic [33:0] dv_curx [DIV_STEPS];
  logic [33:0] dv_cury [DIV_STEPS];
  logic [33:0] dv_den  [DIV_STEPS];
  logic        dv_gex  [DIV_STEPS];
  logic        dv_gey  [DIV_STEPS];
  logic [32:0] dv_remx_next[DIV_STEPS];
  logic [32:0] dv_remy_next[DIV_STEPS];
  logic [30:0] dv_qx_next  [DIV_STEPS];
  logic [30:0] dv_qy_next  [DIV_STEPS];

  always_comb begin
    // dividend is |d| * 2^30; bits above the quotient start the remainder
    dv_sremx[0] = {2'b00, sq_geo[SQ_STEPS-1].dx_mag[31:1]};
    dv_sremy[0] = {2'b00, sq_geo[SQ_STEPS-1].dy_mag[31:1]};
    dv_bitx[0]  = sq_geo[SQ_STEPS-1].dx_mag[0];
    dv_bity[0]  = sq_geo[SQ_STEPS-1].dy_mag[0];
    dv_sqx[0]   = '0;
    dv_sqy[0]   = '0;
    dv_slen[0]  = sq_root[SQ_STEPS-1];
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_sremx[k] = dv_remx[k-1];
      dv_sremy[k] = dv_remy[k-1];
      dv_bitx[k]  = 1'b0;
      dv_bity[k]  = 1'b0;
      dv_sqx[k]   = dv_qx[k-1];
      dv_sqy[k]   = dv_qy[k-1];
      dv_slen[k]  = dv_len[k-1].len;
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      dv_curx[k] = {dv_sremx[k], dv_bitx[k]};
      dv_cury[k] = {dv_sremy[k], dv_bity[k]};
      dv_den[k]  = {1'b0, dv_slen[k]};
      dv_gex[k]  = dv_curx[k] >= dv_den[k];
      dv_gey[k]  = dv_cury[k] >= dv_den[k];
      dv_remx_next[k] = dv_gex[k] ? 33'(dv_curx[k] - dv_den[k]) : dv_curx[k][32:0];
      dv_remy_next[k] = dv_gey[k] ? 33'(dv_cury[k] - dv_den[k]) : dv_cury[k][32:0];
      dv_qx_next[k]   = {dv_sqx[k][29:0], dv_gex[k]};
      dv_qy_next[k]   = {dv_sqy[k][29:0], dv_gey[k]};
    end
  end

  // multiply pipeline; control flags travel alongside
  post_t       pst [1:POST_STAGES];
  logic        pv  [1:POST_STAGES];
  post_t       pst_next;

  logic [62:0] p1_pvx, p1_pvy;
  logic [64:0] p1_kp;
  logic        p1_vxn, p1_vyn, p1_kn;
  logic [33:0] p2_rvx, p2_rvy;
  logic [49:0] p2_ks, p3_ks, p4_ks, p5_ks;
  logic [34:0] p3_rv;
  logic [33:0] p4_rvm;
  logic        p4_rvn, p5_rvn;
  logic [65:0] p5_dp;
  logic [51:0] p6_t;
  logic [50:0] p7_tm;
  logic        p7_tn;
  logic [55:0] p8_pxh, p8_pyh;
  logic [56:0] p8_pxl, p8_pyl;
  logic        p8_fxn, p8_fyn, p9_fxn, p9_fyn;
  logic [81:0] p9_mx, p9_my;
  logic [31:0] p10_fx, p10_fy;

  // combinational pieces of the post stages
  logic [32:0] q2_mx, q2_my;
  logic [48:0] q2_mk;
  logic [34:0] q4_nrv;
  logic [49:0] q6_dm;
  logic [51:0] q6_ks;
  logic [51:0] q7_nt;
  logic [51:0] q10_mx, q10_my;
  logic [31:0] q10_fx, q10_fy;

  function automatic logic [31:0] sat_q16(input logic [51:0] m, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (m > 52'h0_0000_8000_0000) ? 32'h8000_0000 : 32'(-m);
    end else begin
      r = (m > 52'h0_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  always_comb begin
    pst_next.apply_a   = dv_geo[DIV_STEPS-1].apply_a;
    pst_next.apply_b   = dv_geo[DIV_STEPS-1].apply_b;
    pst_next.collapsed = dv_len[DIV_STEPS-1].collapsed;
    pst_next.dx_neg    = dv_geo[DIV_STEPS-1].dx_neg;
    pst_next.dy_neg    = dv_geo[DIV_STEPS-1].dy_neg;
    pst_next.qx        = dv_qx[DIV_STEPS-1];
    pst_next.qy        = dv_qy[DIV_STEPS-1];

    q2_mx  = p1_pvx[62:30];
    q2_my  = p1_pvy[62:30];
    q2_mk  = p1_kp[64:16];
    q4_nrv = -p3_rv;
    q6_dm  = p5_dp[65:16];
    q6_ks  = {p5_ks[49], p5_ks[49], p5_ks};
    q7_nt  = -p6_t;
    q10_mx = p9_mx[81:30];
    q10_my = p9_my[81:30];
    q10_fx = pst[POST_STAGES-1].collapsed ? 32'd0 : sat_q16(q10_mx, p9_fxn);
    q10_fy = pst[POST_STAGES-1].collapsed ? 32'd0 : sat_q16(q10_my, p9_fyn);
  end

  assign last_vld = pv[POST_STAGES];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      for (int j = 0; j < SQ_STEPS; j++) sq_vld[j] <= 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) dv_vld[k] <= 1'b0;
      for (int p = 1; p <= POST_STAGES; p++) pv[p] <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      sq_vld[0] <= s3_vld;
      for (int j = 1; j < SQ_STEPS; j++) sq_vld[j] <= sq_vld[j-1];
      dv_vld[0] <= sq_vld[SQ_STEPS-1];
      for (int k = 1; k < DIV_STEPS; k++) dv_vld[k] <= dv_vld[k-1];
      pv[1] <= dv_vld[DIV_STEPS-1];
      for (int p = 2; p <= POST_STAGES; p++) pv[p] <= pv[p-1];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      s1_geo <= s1_geo_next;
      s2_geo <= s1_geo;
      s2_sqx <= s1_geo.dx_mag * s1_geo.dx_mag;
      s2_sqy <= s1_geo.dy_mag * s1_geo.dy_mag;
      s3_geo <= s2_geo;
      s3_sum <= {2'b00, s2_sqx} + {2'b00, s2_sqy};

      sq_geo[0] <= s3_geo;
      for (int j = 1; j < SQ_STEPS; j++) sq_geo[j] <= sq_geo[j-1];
      for (int j = 0; j < SQ_STEPS; j++) begin
        sq_rem[j]  <= sq_rem_next[j];
        sq_root[j] <= sq_root_next[j];
        sq_rad[j]  <= sq_rad_next[j];
      end

      dv_geo[0] <= sq_geo[SQ_STEPS-1];
      dv_len[0] <= len_next;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_geo[k] <= dv_geo[k-1];
        dv_len[k] <= dv_len[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_remx[k] <= dv_remx_next[k];
        dv_remy[k] <= dv_remy_next[k];
        dv_qx[k]   <= dv_qx_next[k];
        dv_qy[k]   <= dv_qy_next[k];
      end

      pst[1] <= pst_next;
      for (int p = 2; p <= POST_STAGES; p++) pst[p] <= pst[p-1];

      // relative axial velocity products and spring term
      p1_pvx <= dv_geo[DIV_STEPS-1].dvx_mag * dv_qx[DIV_STEPS-1];
      p1_pvy <= dv_geo[DIV_STEPS-1].dvy_mag * dv_qy[DIV_STEPS-1];
      p1_kp  <= stiffness * dv_len[DIV_STEPS-1].disp_mag;
      p1_vxn <= dv_geo[DIV_STEPS-1].dvx_neg ^ dv_geo[DIV_STEPS-1].dx_neg;
      p1_vyn <= dv_geo[DIV_STEPS-1].dvy_neg ^ dv_geo[DIV_STEPS-1].dy_neg;
      p1_kn  <= dv_len[DIV_STEPS-1].disp_neg;

      p2_rvx <= p1_vxn ? -{1'b0, q2_mx} : {1'b0, q2_mx};
      p2_rvy <= p1_vyn ? -{1'b0, q2_my} : {1'b0, q2_my};
      p2_ks  <= p1_kn ? -{1'b0, q2_mk} : {1'b0, q2_mk};

      p3_rv <= {p2_rvx[33], p2_rvx} + {p2_rvy[33], p2_rvy};
      p3_ks <= p2_ks;

      p4_rvn <= p3_rv[34];
      p4_rvm <= p3_rv[34] ? q4_nrv[33:0] : p3_rv[33:0];
      p4_ks  <= p3_ks;

      p5_dp  <= damping * p4_rvm;
      p5_rvn <= p4_rvn;
      p5_ks  <= p4_ks;

      // t = spring - damping; a negative rv flips the damping sign
      p6_t <= p5_rvn ? q6_ks + {2'b00, q6_dm} : q6_ks - {2'b00, q6_dm};

      p7_tn <= p6_t[51];
      p7_tm <= p6_t[51] ? q7_nt[50:0] : p6_t[50:0];

      // t is split in two so each product takes a 25- or 26-bit piece of t
      p8_pxh <= p7_tm[50:26] * pst[7].qx;
      p8_pxl <= p7_tm[25:0]  * pst[7].qx;
      p8_pyh <= p7_tm[50:26] * pst[7].qy;
      p8_pyl <= p7_tm[25:0]  * pst[7].qy;
      p8_fxn <= p7_tn ^ pst[7].dx_neg;
      p8_fyn <= p7_tn ^ pst[7].dy_neg;

      p9_mx  <= {p8_pxh, 26'd0} + {25'd0, p8_pxl};
      p9_my  <= {p8_pyh, 26'd0} + {25'd0, p8_pyl};
      p9_fxn <= p8_fxn;
      p9_fyn <= p8_fyn;

      p10_fx <= q10_fx;
      p10_fy <= q10_fy;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= last_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && last_vld) begin
      force_x   <= p10_fx;
      force_y   <= p10_fy;
      apply_a   <= pst[POST_STAGES].apply_a && !pst[POST_STAGES].collapsed;
      apply_b   <= pst[POST_STAGES].apply_b && !pst[POST_STAGES].collapsed;
      collapsed <= pst[POST_STAGES].collapsed;
    end
  end

endmodule

// ===== src/dsf_checker.sv =====
module dsf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] force_x,
  input logic signed [31:0] force_y,
  input logic               apply_a,
  input logic               apply_b,
  input logic               collapsed
);

  // a collapsed spring carries no force and no apply flags
  assert property (@(posedge clk) disable iff (rst)
    out_valid && collapsed |-> force_x == 32'sd0 && force_y == 32'sd0 && !apply_a && !apply_b)
    else $error("collapsed result carries force");

  // requests are held back only while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(force_x) && $stable(force_y))
    else $error("stalled result changed");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind damped_spring_force dsf_checker u_dsf_checker (.*);
